// File: sv/mcbp_pkg.sv
// ----------------------------------------------------------------------------
// mcbp_pkg
// Types, register indexes, reset values and tables for the barrier pricer.
// ----------------------------------------------------------------------------
package mcbp_pkg;

    localparam int unsigned DEF_MAX_PATHS      = 1048576;
    localparam int unsigned DEF_MAX_STEPS      = 65536;
    localparam int unsigned DEF_EXP_ITERATIONS = 16;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SPOT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BARRIER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS    = 3'd7;

    localparam logic [31:0] RST_SPOT     = 32'd6553600;
    localparam logic [31:0] RST_STRIKE   = 32'd6553600;
    localparam logic [31:0] RST_BARRIER  = 32'd7864320;
    localparam logic [31:0] RST_DRIFT    = 32'd1073741824;
    localparam logic [15:0] RST_VOL      = 16'd6554;
    localparam logic [31:0] RST_DISCOUNT = 32'd2147483648;
    localparam logic [1:0]  RST_KIND     = 2'd1;
    localparam logic [16:0] RST_STEPS    = 17'd100;

    typedef struct packed {
        logic signed [15:0] normal_sample;
        logic               last_sample;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] path_payoff;
        logic        path_hit;
        logic        batch_done;
        logic [31:0] price_mean;
        logic [31:0] price_error;
        logic [20:0] effective_paths;
        logic        sum_saturated;
    } t_out_beat;

    // floor((2^32-1)/k), used for the series term divide
    function automatic logic [31:0] recip(input logic [4:0] k);
        logic [31:0] r;
        begin
            case (k)
                5'd1:    r = 32'd4294967295;
                5'd2:    r = 32'd2147483647;
                5'd3:    r = 32'd1431655765;
                5'd4:    r = 32'd1073741823;
                5'd5:    r = 32'd858993459;
                5'd6:    r = 32'd715827882;
                5'd7:    r = 32'd613566756;
                5'd8:    r = 32'd536870911;
                5'd9:    r = 32'd477218588;
                5'd10:   r = 32'd429496729;
                5'd11:   r = 32'd390451572;
                5'd12:   r = 32'd357913941;
                5'd13:   r = 32'd330382099;
                5'd14:   r = 32'd306783378;
                5'd15:   r = 32'd286331153;
                5'd16:   r = 32'd268435455;
                5'd17:   r = 32'd252645135;
                5'd18:   r = 32'd238609294;
                5'd19:   r = 32'd226050910;
                5'd20:   r = 32'd214748364;
                5'd21:   r = 32'd204522252;
                5'd22:   r = 32'd195225786;
                5'd23:   r = 32'd186737708;
                5'd24:   r = 32'd178956970;
                5'd25:   r = 32'd171798691;
                5'd26:   r = 32'd165191049;
                5'd27:   r = 32'd159072862;
                5'd28:   r = 32'd153391689;
                5'd29:   r = 32'd148102320;
                5'd30:   r = 32'd143165576;
                5'd31:   r = 32'd138547332;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: sv/monte_carlo_barrier_pricer_unit.sv
// ----------------------------------------------------------------------------
// monte_carlo_barrier_pricer_unit
// Monte Carlo barrier option pricer on a shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Input channel: one beat per time step carries a normal draw and the
// batch-end flag. Output channel: one beat at each path end and at the
// batch end; other samples give no beat.
// Configuration is a write port (enable, index, data), written while idle by
// the user; the block itself does not enforce this. A sample runs the series
// loop on the shared multiplier, then the squarings, drift and price update.
// A path end adds the payoff, accumulate and output states. The batch end
// adds three 64-step divides, 32 square root steps and multiplier passes.
// One sample is in work at a time; ready is high only while idle.
// The finished beat sits in an output register; a new sample is accepted
// while it waits, and the block holds at the end of the next item with a
// result until the receiver takes the waiting beat.
// Reset loads the register defaults and clears path and batch state.
// ----------------------------------------------------------------------------
module monte_carlo_barrier_pricer_unit #(
    parameter int unsigned MAX_PATHS      = mcbp_pkg::DEF_MAX_PATHS,
    parameter int unsigned MAX_STEPS      = mcbp_pkg::DEF_MAX_STEPS,
    parameter int unsigned EXP_ITERATIONS = mcbp_pkg::DEF_EXP_ITERATIONS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mcbp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mcbp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mcbp_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mcbp_pkg::t_out_beat                 o_out_data
);

    localparam int unsigned CNT_W = $clog2(MAX_PATHS + 1);

    typedef enum logic [21:0] {
        S_IDLE  = 22'h000001,
        S_X     = 22'h000002,
        S_YINIT = 22'h000004,
        S_T1    = 22'h000008,
        S_T2    = 22'h000010,
        S_T3    = 22'h000020,
        S_T4    = 22'h000040,
        S_SQ0   = 22'h000080,
        S_SQN   = 22'h000100,
        S_DRIFT = 22'h000200,
        S_NLO   = 22'h000400,
        S_NHI   = 22'h000800,
        S_PAY   = 22'h001000,
        S_ACC   = 22'h002000,
        S_BST   = 22'h004000,
        S_DIV   = 22'h008000,
        S_MLO   = 22'h010000,
        S_MHI   = 22'h020000,
        S_MFIN  = 22'h040000,
        S_MSQ   = 22'h080000,
        S_SQRT  = 22'h100000,
        S_OUT   = 22'h200000
    } t_state;

    typedef enum logic [3:0] {
        PH_MEAN = 4'b0001,
        PH_M2A  = 4'b0010,
        PH_M2B  = 4'b0100,
        PH_VAR  = 4'b1000
    } t_phase;

    // configuration
    logic [31:0] r_spot, r_strike, r_barrier, r_drift, r_disc;
    logic [15:0] r_vol;
    logic [1:0]  r_kind;
    logic [16:0] r_steps;

    t_state      r_state;
    t_phase      r_ph;

    logic [16:0] r_zmag;
    logic        r_neg;
    logic        r_last;
    logic [63:0] r_prod;
    logic [29:0] r_y;
    logic [30:0] r_term;
    logic [32:0] r_sum;
    logic [30:0] r_a;
    logic [30:0] r_est;
    logic [5:0]  r_cnt;
    logic [37:0] r_e;
    logic [31:0] r_t;
    logic [37:0] r_lo;
    logic [31:0] r_cur;
    logic        r_hit;
    logic [16:0] r_step;
    logic [CNT_W-1:0] r_pc;
    logic [CNT_W-1:0] r_eff;
    logic [63:0] r_psum, r_qsum;
    logic        r_sat;
    logic [31:0] r_payoff;
    logic        r_hit_out;
    logic [63:0] r_dq;
    logic [CNT_W-1:0] r_dr;
    logic [63:0] r_mx, r_b, r_m2;
    logic [31:0] r_mean, r_err;
    logic [63:0] r_sv, r_sres, r_sbit;
    logic        r_oval;
    mcbp_pkg::t_out_beat r_out;

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;

    logic [16:0] in_zmag;
    logic [31:0] base;
    logic [31:0] t_sat;
    logic [44:0] np_sum;
    logic [31:0] np;
    logic        hit_new;
    logic [16:0] steps_eff;
    logic        path_end;
    logic [31:0] pay_raw, payoff_c;
    logic        pay_eff;
    logic [30:0] t4_rem;
    logic        t4_ge;
    logic [30:0] t4_q;
    logic [32:0] sum_next;
    logic [64:0] psum_add, qsum_add;
    logic [CNT_W:0] d_sh, d_rem;
    logic        d_ge;
    logic [63:0] d_q;
    logic [64:0] m_sum;
    logic [63:0] m_res;
    logic [31:0] m_sat32;
    logic [63:0] s_t, s_res_n;
    logic        s_ge;
    logic [63:0] var_c;

    assign in_zmag = i_in_data.normal_sample[15]
                   ? (17'h10000 - {1'b0, i_in_data.normal_sample})
                   : {1'b0, i_in_data.normal_sample};

    assign base  = (r_step == 17'd0) ? r_spot : r_cur;
    assign t_sat = (|r_prod[63:62]) ? 32'hFFFF_FFFF : r_prod[61:30];

    assign np_sum  = {1'b0, r_prod[37:0], 6'b0} + {7'b0, r_lo};
    assign np      = (|np_sum[44:32]) ? 32'hFFFF_FFFF : np_sum[31:0];
    assign hit_new = r_hit || (np == r_barrier) ||
                     ((base > r_barrier) != (np > r_barrier));

    assign steps_eff = (r_steps == 17'd0) ? 17'd1 :
                       (r_steps > 17'(MAX_STEPS)) ? 17'(MAX_STEPS) : r_steps;
    assign path_end  = ({1'b0, r_step} + 18'd1) >= {1'b0, steps_eff};

    assign pay_raw  = r_kind[0] ? ((r_cur > r_strike) ? r_cur - r_strike : 32'd0)
                                : ((r_strike > r_cur) ? r_strike - r_cur : 32'd0);
    assign pay_eff  = r_kind[1] ? !r_hit_out : r_hit_out;
    assign payoff_c = pay_eff ? pay_raw : 32'd0;

    assign t4_rem = r_a - r_prod[30:0];
    assign t4_ge  = t4_rem >= 31'(r_cnt);
    assign t4_q   = r_est + 31'(t4_ge);
    assign sum_next = (r_neg && r_cnt[0])
                    ? ((33'(t4_q) > r_sum) ? 33'd0 : r_sum - 33'(t4_q))
                    : r_sum + 33'(t4_q);

    assign psum_add = {1'b0, r_psum} + 65'(r_payoff);
    assign qsum_add = {1'b0, r_qsum} + {1'b0, r_prod};

    assign d_sh  = {r_dr, r_dq[63]};
    assign d_ge  = d_sh >= {1'b0, r_pc};
    assign d_rem = d_ge ? d_sh - {1'b0, r_pc} : d_sh;
    assign d_q   = {r_dq[62:0], d_ge};

    assign m_sum   = {r_prod, 1'b0} + {32'b0, r_b[63:31]};
    assign m_res   = m_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m_sum[63:0];
    assign m_sat32 = (|m_res[63:32]) ? 32'hFFFF_FFFF : m_res[31:0];

    assign var_c = (r_m2 > r_prod) ? r_m2 - r_prod : 64'd0;

    assign s_t     = r_sres + r_sbit;
    assign s_ge    = r_sv >= s_t;
    assign s_res_n = s_ge ? (r_sres >> 1) + r_sbit : (r_sres >> 1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_X: begin
                mul_a = 32'(r_vol);
                mul_b = 32'(r_zmag);
            end
            S_T1: begin
                mul_a = 32'(r_term);
                mul_b = 32'(r_y);
            end
            S_T2: begin
                mul_a = 32'(r_prod[60:30]);
                mul_b = mcbp_pkg::recip(r_cnt[4:0]);
            end
            S_T3: begin
                mul_a = r_prod[63:32];
                mul_b = 32'(r_cnt);
            end
            S_SQ0: begin
                mul_a = 32'(r_sum[32:4]);
                mul_b = 32'(r_sum[32:4]);
            end
            S_SQN: begin
                if (r_cnt == 6'd2) begin
                    mul_a = base;
                    mul_b = r_drift;
                end else begin
                    mul_a = r_prod[57:26];
                    mul_b = r_prod[57:26];
                end
            end
            S_DRIFT: begin
                mul_a = r_e[31:0];
                mul_b = t_sat;
            end
            S_NLO: begin
                mul_a = 32'(r_e[37:32]);
                mul_b = r_t;
            end
            S_PAY: begin
                mul_a = payoff_c;
                mul_b = payoff_c;
            end
            S_MLO: begin
                mul_a = r_mx[31:0];
                mul_b = r_disc;
            end
            S_MHI: begin
                mul_a = r_mx[63:32];
                mul_b = r_disc;
            end
            S_MFIN: begin
                mul_a = r_mean;
                mul_b = r_mean;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        if (!i_rst_n) begin
            r_spot    <= mcbp_pkg::RST_SPOT;
            r_strike  <= mcbp_pkg::RST_STRIKE;
            r_barrier <= mcbp_pkg::RST_BARRIER;
            r_drift   <= mcbp_pkg::RST_DRIFT;
            r_vol     <= mcbp_pkg::RST_VOL;
            r_disc    <= mcbp_pkg::RST_DISCOUNT;
            r_kind    <= mcbp_pkg::RST_KIND;
            r_steps   <= mcbp_pkg::RST_STEPS;
            r_state   <= S_IDLE;
            r_ph      <= PH_MEAN;
            r_cnt     <= 6'd0;
            r_hit     <= 1'b0;
            r_step    <= 17'd0;
            r_pc      <= '0;
            r_eff     <= '0;
            r_psum    <= 64'd0;
            r_qsum    <= 64'd0;
            r_sat     <= 1'b0;
            r_last    <= 1'b0;
            r_oval    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    mcbp_pkg::CFG_SPOT:     r_spot    <= i_cfg_wdata;
                    mcbp_pkg::CFG_STRIKE:   r_strike  <= i_cfg_wdata;
                    mcbp_pkg::CFG_BARRIER:  r_barrier <= i_cfg_wdata;
                    mcbp_pkg::CFG_DRIFT:    r_drift   <= i_cfg_wdata;
                    mcbp_pkg::CFG_VOL:      r_vol     <= i_cfg_wdata[15:0];
                    mcbp_pkg::CFG_DISCOUNT: r_disc    <= i_cfg_wdata;
                    mcbp_pkg::CFG_KIND:     r_kind    <= i_cfg_wdata[1:0];
                    mcbp_pkg::CFG_STEPS:    r_steps   <= i_cfg_wdata[16:0];
                    default: ;
                endcase
            end

            if (r_oval && i_out_ready && r_state != S_OUT) begin
                r_oval <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_zmag  <= in_zmag;
                        r_neg   <= i_in_data.normal_sample[15];
                        r_last  <= i_in_data.last_sample;
                        r_state <= S_X;
                    end
                end
                S_X: begin
                    r_state <= S_YINIT;
                end
                S_YINIT: begin
                    r_y     <= r_prod[30:1];
                    r_term  <= 31'h4000_0000;
                    r_sum   <= 33'h0_4000_0000;
                    r_cnt   <= 6'd1;
                    r_state <= S_T1;
                end
                S_T1: begin
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_a     <= r_prod[60:30];
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_est   <= r_prod[62:32];
                    r_state <= S_T4;
                end
                S_T4: begin
                    r_term <= t4_q;
                    r_sum  <= sum_next;
                    if (r_cnt == 6'(EXP_ITERATIONS - 1)) begin
                        r_state <= S_SQ0;
                    end else begin
                        r_cnt   <= r_cnt + 6'd1;
                        r_state <= S_T1;
                    end
                end
                S_SQ0: begin
                    r_cnt   <= 6'd0;
                    r_state <= S_SQN;
                end
                S_SQN: begin
                    if (r_cnt == 6'd2) begin
                        r_e     <= r_prod[63:26];
                        r_state <= S_DRIFT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DRIFT: begin
                    r_t     <= t_sat;
                    r_state <= S_NLO;
                end
                S_NLO: begin
                    r_lo    <= r_prod[63:26];
                    r_state <= S_NHI;
                end
                S_NHI: begin
                    r_cur <= np;
                    if (path_end) begin
                        r_hit_out <= hit_new;
                        r_hit     <= 1'b0;
                        r_step    <= 17'd0;
                        r_state   <= S_PAY;
                    end else begin
                        r_hit  <= hit_new;
                        r_step <= r_step + 17'd1;
                        if (r_last) begin
                            r_payoff  <= 32'd0;
                            r_hit_out <= 1'b0;
                            r_state   <= S_BST;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PAY: begin
                    r_payoff <= payoff_c;
                    r_state  <= S_ACC;
                end
                S_ACC: begin
                    if (r_pc < CNT_W'(MAX_PATHS)) begin
                        r_pc <= r_pc + 1'b1;
                        if (pay_eff) begin
                            r_eff <= r_eff + 1'b1;
                        end
                        r_sat <= r_sat | psum_add[64] | qsum_add[64];
                        if (psum_add[64]) begin
                            r_psum <= 64'hFFFF_FFFF_FFFF_FFFF;
                        end else begin
                            r_psum <= psum_add[63:0];
                        end
                        if (qsum_add[64]) begin
                            r_qsum <= 64'hFFFF_FFFF_FFFF_FFFF;
                        end else begin
                            r_qsum <= qsum_add[63:0];
                        end
                    end
                    r_state <= r_last ? S_BST : S_OUT;
                end
                S_BST: begin
                    if (r_pc == '0) begin
                        r_mean  <= 32'd0;
                        r_err   <= 32'd0;
                        r_state <= S_OUT;
                    end else begin
                        r_dq    <= r_psum;
                        r_dr    <= '0;
                        r_cnt   <= 6'd0;
                        r_ph    <= PH_MEAN;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dq  <= d_q;
                    r_dr  <= d_rem[CNT_W-1:0];
                    if (r_cnt == 6'd63) begin
                        r_cnt <= 6'd0;
                        if (r_ph == PH_VAR) begin
                            r_sv    <= d_q;
                            r_sres  <= 64'd0;
                            r_sbit  <= 64'h4000_0000_0000_0000;
                            r_state <= S_SQRT;
                        end else begin
                            r_mx    <= d_q;
                            r_state <= S_MLO;
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_MLO: begin
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_b     <= r_prod;
                    r_state <= S_MFIN;
                end
                S_MFIN: begin
                    case (r_ph)
                        PH_MEAN: begin
                            r_mean  <= m_sat32;
                            r_dq    <= r_qsum;
                            r_dr    <= '0;
                            r_cnt   <= 6'd0;
                            r_ph    <= PH_M2A;
                            r_state <= S_DIV;
                        end
                        PH_M2A: begin
                            r_mx    <= m_res;
                            r_ph    <= PH_M2B;
                            r_state <= S_MLO;
                        end
                        PH_M2B: begin
                            r_m2    <= m_res;
                            r_state <= S_MSQ;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_MSQ: begin
                    r_dq    <= var_c;
                    r_dr    <= '0;
                    r_cnt   <= 6'd0;
                    r_ph    <= PH_VAR;
                    r_state <= S_DIV;
                end
                S_SQRT: begin
                    if (s_ge) begin
                        r_sv <= r_sv - s_t;
                    end
                    r_sres <= s_res_n;
                    r_sbit <= r_sbit >> 2;
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_err   <= s_res_n[31:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_oval || i_out_ready) begin
                        r_oval                <= 1'b1;
                        r_out.path_payoff     <= r_payoff;
                        r_out.path_hit        <= r_hit_out;
                        r_out.batch_done      <= r_last;
                        r_out.price_mean      <= r_last ? r_mean : 32'd0;
                        r_out.price_error     <= r_last ? r_err : 32'd0;
                        r_out.effective_paths <= r_last ? 21'(r_eff) : 21'd0;
                        r_out.sum_saturated   <= r_last && r_sat;
                        if (r_last) begin
                            r_hit  <= 1'b0;
                            r_step <= 17'd0;
                            r_pc   <= '0;
                            r_eff  <= '0;
                            r_psum <= 64'd0;
                            r_qsum <= 64'd0;
                            r_sat  <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: dv/monte_carlo_barrier_pricer_unit_tb.sv
// ----------------------------------------------------------------------------
// monte_carlo_barrier_pricer_unit_tb
// Self-checking bench for the Monte Carlo barrier pricer. Normal draws are
// fed beat by beat over several register settings; a bit-true model of the
// path price, barrier flag, payoff and batch statistics predicts each output
// beat, which is compared field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module monte_carlo_barrier_pricer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned N_PATH_CAP = mcbp_pkg::DEF_MAX_PATHS;
    localparam int unsigned N_STEP_CAP = mcbp_pkg::DEF_MAX_STEPS;
    localparam int unsigned N_TERMS    = mcbp_pkg::DEF_EXP_ITERATIONS;
    localparam int unsigned CYC_LIMIT  = 3000000;
    localparam int unsigned DRAIN_CYC  = 400;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_wr_en;
    logic [mcbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [mcbp_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                            i_in_valid;
    logic                            o_in_ready;
    mcbp_pkg::t_in_beat              i_in_data;
    logic                            o_out_valid;
    logic                            i_out_ready;
    mcbp_pkg::t_out_beat             o_out_data;

    monte_carlo_barrier_pricer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // register shadow
    logic [31:0] r_spot, r_strike, r_barrier, r_drift, r_disc;
    logic [15:0] r_vol;
    logic [1:0]  r_kind;
    logic [16:0] r_steps;
    // path and batch shadow
    logic [31:0] m_price;
    logic        m_hit;
    int unsigned m_step, m_paths, m_eff;
    logic [63:0] m_sum, m_sqsum;
    logic        m_sat;

    mcbp_pkg::t_out_beat beats_due[$];
    int unsigned n_err, n_beats, n_batches, n_sats, cyc;
    bit          rx_noidle, rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] mul_shift(logic [63:0] x, logic [31:0] y, int s);
        logic [127:0] p;
        p = ({64'd0, x} * {96'd0, y}) >> s;
        return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    function automatic logic [31:0] clip32(logic [63:0] v);
        return (v[63:32] != 0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [63:0] exp_q26(logic [63:0] mag, logic neg);
        logic [63:0] y, term, acc, s;
        y = mag >> 1;
        term = 64'd1 << 30;
        acc = term;
        for (int k = 1; k < N_TERMS; k++) begin
            term = ((term * y) >> 30) / k;
            if (neg && k[0]) acc = (term > acc) ? 64'd0 : acc - term;
            else acc = acc + term;
        end
        s = acc >> 4;
        for (int k = 0; k < 3; k++) s = (s * s) >> 26;
        return s;
    endfunction

    function automatic logic [63:0] sqrt64(logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void clear_batch();
        m_price = r_spot; m_hit = 0; m_step = 0; m_paths = 0;
        m_sum = 0; m_sqsum = 0; m_eff = 0; m_sat = 0;
    endfunction

    task automatic shadow_write(logic [mcbp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
        case (idx)
            mcbp_pkg::CFG_SPOT:     r_spot = v;
            mcbp_pkg::CFG_STRIKE:   r_strike = v;
            mcbp_pkg::CFG_BARRIER:  r_barrier = v;
            mcbp_pkg::CFG_DRIFT:    r_drift = v;
            mcbp_pkg::CFG_VOL:      r_vol = v[15:0];
            mcbp_pkg::CFG_DISCOUNT: r_disc = v;
            mcbp_pkg::CFG_KIND:     r_kind = v[1:0];
            default:                r_steps = v[16:0];
        endcase
    endtask

    // advance the path model by one draw; returns 1 and the beat if one is due
    function automatic bit price_step(mcbp_pkg::t_in_beat b, output mcbp_pkg::t_out_beat o);
        logic [15:0] raw;
        logic        neg, pend, eff, hit_o;
        logic [63:0] zmag, e, sq, m2, msq, var_q, n;
        logic [31:0] base, t, np, pay, mean;
        int unsigned steps;
        raw = b.normal_sample;
        neg = raw[15];
        zmag = neg ? 64'(17'h10000 - raw) : 64'(raw);
        base = (m_step == 0) ? r_spot : m_price;
        steps = r_steps;
        pay = 0;
        hit_o = 0;
        o = '0;
        if (steps == 0) steps = 1;
        if (steps > N_STEP_CAP) steps = N_STEP_CAP;
        e = exp_q26(64'(r_vol) * zmag, neg);
        t = clip32((64'(base) * r_drift) >> 30);
        np = clip32(mul_shift(e, t, 26));
        m_hit = m_hit || np == r_barrier || ((base > r_barrier) != (np > r_barrier));
        m_price = np;
        pend = (m_step + 1 >= steps);
        if (pend) begin
            eff = r_kind[1] ? !m_hit : m_hit;
            if (r_kind[0]) pay = (np > r_strike) ? np - r_strike : 0;
            else pay = (r_strike > np) ? r_strike - np : 0;
            if (!eff) pay = 0;
            hit_o = m_hit;
            if (m_paths < N_PATH_CAP) begin
                sq = 64'(pay) * pay;
                m_paths++;
                if (eff) m_eff++;
                if (m_sum > ~64'd0 - pay) begin
                    m_sum = ~64'd0; m_sat = 1;
                end else begin
                    m_sum += pay;
                end
                if (m_sqsum > ~64'd0 - sq) begin
                    m_sqsum = ~64'd0; m_sat = 1;
                end else begin
                    m_sqsum += sq;
                end
            end
            m_step = 0;
            m_hit = 0;
        end else begin
            m_step++;
        end
        if (!pend && !b.last_sample) return 0;
        o.path_payoff = pay;
        o.path_hit = hit_o;
        if (b.last_sample) begin
            mean = 0;
            var_q = 0;
            if (m_paths > 0) begin
                n = m_paths;
                mean = clip32(mul_shift(m_sum / n, r_disc, 31));
                m2 = mul_shift(mul_shift(m_sqsum / n, r_disc, 31), r_disc, 31);
                msq = 64'(mean) * mean;
                var_q = (m2 > msq) ? sqrt64((m2 - msq) / n) : 64'd0;
            end
            o.batch_done = 1;
            o.price_mean = mean;
            o.price_error = var_q[31:0];
            o.effective_paths = m_eff[20:0];
            o.sum_saturated = m_sat;
            clear_batch();
        end
        return 1;
    endfunction

    // receiver with random stalls and an optional long hold-off
    initial begin
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold) begin
                i_out_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                rx_hold = 0;
            end
            if (!rx_noidle && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 19);
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        mcbp_pkg::t_out_beat w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_beats++;
            if (beats_due.size() == 0) begin
                $error("unexpected output beat %h", o_out_data);
                n_err++;
            end else begin
                w = beats_due.pop_front();
                if (w.batch_done) n_batches++;
                if (w.sum_saturated) n_sats++;
                if (o_out_data.path_payoff !== w.path_payoff) begin
                    $error("path_payoff exp %h got %h", w.path_payoff, o_out_data.path_payoff);
                    n_err++;
                end
                if (o_out_data.path_hit !== w.path_hit) begin
                    $error("path_hit exp %b got %b", w.path_hit, o_out_data.path_hit);
                    n_err++;
                end
                if (o_out_data.batch_done !== w.batch_done) begin
                    $error("batch_done exp %b got %b", w.batch_done, o_out_data.batch_done);
                    n_err++;
                end
                if (o_out_data.price_mean !== w.price_mean) begin
                    $error("price_mean exp %h got %h", w.price_mean, o_out_data.price_mean);
                    n_err++;
                end
                if (o_out_data.price_error !== w.price_error) begin
                    $error("price_error exp %h got %h", w.price_error, o_out_data.price_error);
                    n_err++;
                end
                if (o_out_data.effective_paths !== w.effective_paths) begin
                    $error("effective_paths exp %0d got %0d", w.effective_paths,
                           o_out_data.effective_paths);
                    n_err++;
                end
                if (o_out_data.sum_saturated !== w.sum_saturated) begin
                    $error("sum_saturated exp %b got %b", w.sum_saturated,
                           o_out_data.sum_saturated);
                    n_err++;
                end
            end
        end
    end

    task automatic cfg_write(logic [mcbp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        shadow_write(idx, v);
        clear_batch();
    endtask

    task automatic wait_idle();
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // one beat; idle_ok allows a random gap first; chk is a typed-in expectation
    task automatic send_beat(logic [15:0] z, logic last, bit idle_ok,
                             bit has_chk = 0, mcbp_pkg::t_out_beat chk = '0);
        mcbp_pkg::t_in_beat  b;
        mcbp_pkg::t_out_beat o;
        bit                  due;
        if (idle_ok && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        b.normal_sample = z;
        b.last_sample = last;
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk iff o_in_ready);
        due = price_step(b, o);
        if (has_chk) begin
            if (!due || o !== chk) begin
                $error("typed-in expectation differs from predictor: %h vs %h", chk, o);
                n_err++;
            end
        end
        if (due) beats_due.push_back(o);
    endtask

    task automatic drop_valid();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_draw();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'($urandom());
            default: return 16'($signed($urandom_range(0, 16384)) - 8192);
        endcase
    endfunction

    typedef struct {
        logic [15:0]         z;
        logic                last;
        bit                  typed;
        mcbp_pkg::t_out_beat chk;
    } t_row;

    initial begin
        t_row                rows[$];
        t_row                r;
        mcbp_pkg::t_out_beat empty_done;
        logic [31:0]         regs[8];
        int                  batch_len;
        bit                  done_rand;

        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        n_err = 0; n_beats = 0; n_batches = 0; n_sats = 0; cyc = 0;
        rx_noidle = 0; rx_hold = 0;
        r_spot = mcbp_pkg::RST_SPOT; r_strike = mcbp_pkg::RST_STRIKE;
        r_barrier = mcbp_pkg::RST_BARRIER; r_drift = mcbp_pkg::RST_DRIFT;
        r_vol = mcbp_pkg::RST_VOL; r_disc = mcbp_pkg::RST_DISCOUNT;
        r_kind = mcbp_pkg::RST_KIND; r_steps = mcbp_pkg::RST_STEPS;
        clear_batch();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: last sample in an empty batch gives an all-zero summary
        empty_done = '0;
        empty_done.batch_done = 1'b1;
        send_beat(16'h0000, 1'b1, 0, 1, empty_done);
        drop_valid();
        wait_idle();

        // short paths, extreme draws, all option kinds
        cfg_write(mcbp_pkg::CFG_STEPS, 32'd2);
        rows = {};
        r.typed = 0; r.chk = '0;
        foreach (regs[i]) regs[i] = 0;
        for (int k = 0; k < 4; k++) begin
            wait_idle();
            cfg_write(mcbp_pkg::CFG_KIND, k);
            cfg_write(mcbp_pkg::CFG_BARRIER, (k < 2) ? 32'd7000000 : 32'd6000000);
            r.z = 16'h7FFF; r.last = 0; rows.push_back(r);
            r.z = 16'h8000; r.last = 0; rows.push_back(r);
            r.z = 16'h1000; r.last = 0; rows.push_back(r);
            r.z = 16'hF000; r.last = 1; rows.push_back(r);
            foreach (rows[i]) send_beat(rows[i].z, rows[i].last, 0,
                                        rows[i].typed, rows[i].chk);
            rows = {};
            drop_valid();
        end

        // step count of zero acts as one
        wait_idle();
        cfg_write(mcbp_pkg::CFG_STEPS, 32'd0);
        send_beat(16'h0000, 0, 0);
        send_beat(16'h7FFF, 1, 0);
        drop_valid();

        // price overflow: huge spot and drift
        wait_idle();
        cfg_write(mcbp_pkg::CFG_SPOT, 32'hFFFF_FFFF);
        cfg_write(mcbp_pkg::CFG_DRIFT, 32'hFFFF_FFFF);
        cfg_write(mcbp_pkg::CFG_VOL, 32'hFFFF);
        cfg_write(mcbp_pkg::CFG_STRIKE, 32'd0);
        cfg_write(mcbp_pkg::CFG_KIND, 32'd3);
        cfg_write(mcbp_pkg::CFG_BARRIER, 32'hFFFF_FFFF);
        cfg_write(mcbp_pkg::CFG_DISCOUNT, 32'h8000_0000);
        cfg_write(mcbp_pkg::CFG_STEPS, 32'd1);
        for (int i = 0; i < 6; i++) send_beat(16'h7FFF, i == 5, 0);
        drop_valid();

        // random phases over varied settings
        for (int ph = 0; ph < 14; ph++) begin
            wait_idle();
            cfg_write(mcbp_pkg::CFG_SPOT, (ph == 1) ? 32'd0 :
                      $urandom_range(32'h0001_0000, 32'h0200_0000));
            cfg_write(mcbp_pkg::CFG_STRIKE, $urandom_range(32'h0001_0000, 32'h0200_0000));
            cfg_write(mcbp_pkg::CFG_BARRIER, (ph == 2) ? 32'd0 :
                      (ph == 3) ? 32'hFFFF_FFFF : $urandom_range(32'h0001_0000, 32'h0300_0000));
            cfg_write(mcbp_pkg::CFG_DRIFT, (ph == 4) ? 32'd0 : (ph == 5) ? 32'hFFFF_FFFF :
                      $urandom_range(32'h3F00_0000, 32'h4100_0000));
            cfg_write(mcbp_pkg::CFG_VOL, (ph == 6) ? 32'd0 : (ph == 7) ? 32'hFFFF :
                      $urandom_range(0, 20000));
            cfg_write(mcbp_pkg::CFG_DISCOUNT, (ph == 8) ? 32'd0 :
                      $urandom_range(32'h6000_0000, 32'h8000_0000));
            cfg_write(mcbp_pkg::CFG_KIND, $urandom_range(0, 3));
            cfg_write(mcbp_pkg::CFG_STEPS, (ph == 9) ? 32'h1FFFF : (ph == 10) ? 32'd1 :
                      $urandom_range(1, 6));
            rx_noidle = (ph >= 12);
            if (ph == 11) rx_hold = 1;
            done_rand = 0;
            for (int i = 0; i < 85 && !done_rand; i++) begin
                batch_len = (ph == 9) ? 40 : $urandom_range(3, 30);
                for (int j = 0; j < batch_len; j++) begin
                    send_beat(rand_draw(), j == batch_len - 1 || $urandom_range(0, 199) == 0,
                              ph < 12);
                    i++;
                end
                if (i >= 85) done_rand = 1;
            end
            drop_valid();
            if (ph == 6) while (beats_due.size() != 0) @(posedge i_clk);
        end

        drop_valid();
        wait_idle();
        $display("covered %0d output beats, %0d batch summaries, %0d saturated", n_beats,
                 n_batches, n_sats);
        $display("settings swept: all option kinds, step and price extremes, long stalls");
        if (n_err == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
